[hdl/ppc_pkg.sv]
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types and codes for the point projection colorizer.
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int CoefBits = 32;
  localparam int DotBits  = 66;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_COEF  = 2'd1,
    OP_POINT = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_WIDTH_ONE  = 2'd0,
    REG_HEIGHT_ONE = 2'd1,
    REG_WIDTH_TWO  = 2'd2,
    REG_HEIGHT_TWO = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic               camera;
    logic [9:0]         pixel_column;
    logic [8:0]         pixel_row;
    logic [23:0]        pixel_color;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic       color_found;
    logic       source_camera;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  // projected coordinates of one camera
  typedef struct packed {
    logic signed [DotBits-1:0] px;
    logic signed [DotBits-1:0] py;
    logic signed [DotBits-1:0] pz;
  } proj_t;

  // outcome of the division and range test for one camera
  typedef struct packed {
    logic        hit;
    logic [11:0] col;
    logic [11:0] row;
  } hit_t;

endpackage

[hdl/point_projection_colorizer_core.sv]
// ----------------------------------------------------------------------------
// point_projection_colorizer_core
// Colours points by projecting them into two stored camera frames.
// ----------------------------------------------------------------------------
// channel | ports                         | transfer
// input   | start, busy, in_item          | start && !busy
// result  | out_valid, out_item           | out_valid, one cycle
// config  | cfg_we, cfg_index, cfg_data   | cfg_we
// out_valid rises after a point's project, divide, range test, read and output
// stages, most in the divider, one bit a stage. One item enters every cycle.
// busy is low at all times; results cannot be stalled.
// Reset clears matrices and frame ready bits; frame stores are not cleared.
// Coefficient writes take effect in the cycle after start; pixel writes reach
// the frame stores after the point depth, in step with the point reads.
module point_projection_colorizer_core
  import ppc_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = CW + RW;
  localparam int PIPE = 2 + 14 + 1; // project, divide, range test

  typedef struct packed {
    logic          we;
    logic          cam;
    logic [AW-1:0] addr;
    logic [23:0]   data;
  } pix_wr_t;

  logic [10:0] width_one_r, width_two_r;
  logic [9:0]  height_one_r, height_two_r;
  logic [11:0] w1, h1, w2, h2;
  logic signed [CoefBits-1:0] mat_one_r [12];
  logic signed [CoefBits-1:0] mat_two_r [12];
  logic [1:0] ready_r;
  logic [PIPE-1:0] vld_r;
  logic [23:0] frame_one [2**AW];
  logic [23:0] frame_two [2**AW];
  proj_t p1, p2;
  hit_t hit1, hit2;
  logic [23:0] rd1_r, rd2_r;
  logic hit1_r, hit2_r, vmem_r;
  logic acc;
  logic [11:0] wu, hu;
  pix_wr_t wr_r [PIPE];

  function automatic logic [11:0] clip(input logic [11:0] v, input logic [12:0] m);
    clip = ({1'b0, v} < m) ? v : m[11:0];
  endfunction

  assign busy = 1'b0;
  assign acc  = start;
  assign w1 = clip({1'b0, width_one_r}, 13'(MAX_WIDTH));
  assign h1 = clip({2'b0, height_one_r}, 13'(MAX_HEIGHT));
  assign w2 = clip({1'b0, width_two_r}, 13'(MAX_WIDTH));
  assign h2 = clip({2'b0, height_two_r}, 13'(MAX_HEIGHT));
  assign wu = in_item.camera ? w2 : w1;
  assign hu = in_item.camera ? h2 : h1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_one_r  <= 11'd640;
      height_one_r <= 10'd480;
      width_two_r  <= 11'd640;
      height_two_r <= 10'd480;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WIDTH_ONE:  width_one_r  <= cfg_data;
        REG_HEIGHT_ONE: height_one_r <= cfg_data[9:0];
        REG_WIDTH_TWO:  width_two_r  <= cfg_data;
        REG_HEIGHT_TWO: height_two_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 12; i++) begin
        mat_one_r[i] <= '0;
        mat_two_r[i] <= '0;
      end
      ready_r <= '0;
      vld_r   <= '0;
    end else begin
      vld_r <= {vld_r[PIPE-2:0],
                acc && op_t'(in_item.operation) == OP_POINT && ready_r == 2'b11};
      if (acc && op_t'(in_item.operation) == OP_COEF && in_item.coef_index < 4'd12) begin
        if (in_item.camera) mat_two_r[in_item.coef_index] <= in_item.coef_value;
        else                mat_one_r[in_item.coef_index] <= in_item.coef_value;
      end
      if (acc && op_t'(in_item.operation) == OP_PIXEL
          && 13'(in_item.pixel_column) < 13'(MAX_WIDTH)
          && 13'(in_item.pixel_row) < 13'(MAX_HEIGHT)
          && wu != '0 && hu != '0
          && 12'(in_item.pixel_column) == wu - 12'd1
          && 12'(in_item.pixel_row) == hu - 12'd1) begin
        ready_r[in_item.camera] <= 1'b1;
      end
    end
  end

  // frame stores: one write port, one registered read port each
  logic pix_we;
  logic [AW-1:0] pix_addr;
  assign pix_we = acc && op_t'(in_item.operation) == OP_PIXEL
                  && 13'(in_item.pixel_column) < 13'(MAX_WIDTH)
                  && 13'(in_item.pixel_row) < 13'(MAX_HEIGHT);
  assign pix_addr = {RW'(in_item.pixel_row), CW'(in_item.pixel_column)};

  // pixel writes trail their transfer by the point depth, so a point reads
  // the store as it stood when the point was taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE; i++) wr_r[i] <= '0;
    end else begin
      wr_r[0].we   <= pix_we;
      wr_r[0].cam  <= in_item.camera;
      wr_r[0].addr <= pix_addr;
      wr_r[0].data <= in_item.pixel_color;
      for (int i = 1; i < PIPE; i++) wr_r[i] <= wr_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_r[PIPE-1].we && !wr_r[PIPE-1].cam) frame_one[wr_r[PIPE-1].addr] <= wr_r[PIPE-1].data;
    if (wr_r[PIPE-1].we &&  wr_r[PIPE-1].cam) frame_two[wr_r[PIPE-1].addr] <= wr_r[PIPE-1].data;
    rd1_r <= frame_one[{RW'(hit1.row), CW'(hit1.col)}];
    rd2_r <= frame_two[{RW'(hit2.row), CW'(hit2.col)}];
    hit1_r <= hit1.hit;
    hit2_r <= hit2.hit;
  end

  ppc_project #(.FRAC_BITS(FRAC_BITS)) u_project (
    .clk(clk), .mat_one(mat_one_r), .mat_two(mat_two_r),
    .x(in_item.point_x), .y(in_item.point_y), .z(in_item.point_z),
    .proj_one(p1), .proj_two(p2)
  );

  ppc_divide u_div_one (.clk(clk), .proj(p1), .w_used(w1), .h_used(h1), .hit(hit1));
  ppc_divide u_div_two (.clk(clk), .proj(p2), .w_used(w2), .h_used(h2), .hit(hit2));

  always_ff @(posedge clk) begin
    if (!rst_n) vmem_r <= 1'b0;
    else        vmem_r <= vld_r[PIPE-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vmem_r;
    end
    out_item.color_found   <= hit1_r || hit2_r;
    out_item.source_camera <= !hit1_r && hit2_r;
    if (hit1_r)      {out_item.red, out_item.green, out_item.blue} <= rd1_r;
    else if (hit2_r) {out_item.red, out_item.green, out_item.blue} <= rd2_r;
    else             {out_item.red, out_item.green, out_item.blue} <= '0;
  end

endmodule

[hdl/ppc_project.sv]
// ----------------------------------------------------------------------------
// ppc_project
// Matrix times point for both cameras: products registered, then row sums.
// Two stages.
// ----------------------------------------------------------------------------
module ppc_project
  import ppc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic signed [CoefBits-1:0] mat_one [12],
  input  logic signed [CoefBits-1:0] mat_two [12],
  input  logic signed [31:0]         x,
  input  logic signed [31:0]         y,
  input  logic signed [31:0]         z,
  output proj_t                      proj_one,
  output proj_t                      proj_two
);

  logic signed [63:0] prod_r [2][9];
  logic signed [31:0] trans_r [2][3];
  logic signed [DotBits-1:0] sum_nxt [2][3];
  proj_t proj_r [2];

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      prod_r[0][3*r]   <= mat_one[4*r]   * x;
      prod_r[0][3*r+1] <= mat_one[4*r+1] * y;
      prod_r[0][3*r+2] <= mat_one[4*r+2] * z;
      prod_r[1][3*r]   <= mat_two[4*r]   * x;
      prod_r[1][3*r+1] <= mat_two[4*r+1] * y;
      prod_r[1][3*r+2] <= mat_two[4*r+2] * z;
      trans_r[0][r]    <= mat_one[4*r+3];
      trans_r[1][r]    <= mat_two[4*r+3];
    end
  end

  // arithmetic shift is the floor of the q16.16 product
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      for (int r = 0; r < 3; r++) begin
        sum_nxt[c][r] = DotBits'(prod_r[c][3*r]   >>> FRAC_BITS)
                      + DotBits'(prod_r[c][3*r+1] >>> FRAC_BITS)
                      + DotBits'(prod_r[c][3*r+2] >>> FRAC_BITS)
                      + DotBits'(trans_r[c][r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 2; c++) begin
      proj_r[c].px <= sum_nxt[c][0];
      proj_r[c].py <= sum_nxt[c][1];
      proj_r[c].pz <= sum_nxt[c][2];
    end
  end

  assign proj_one = proj_r[0];
  assign proj_two = proj_r[1];

endmodule

[hdl/ppc_divide.sv]
// ----------------------------------------------------------------------------
// ppc_divide
// Pipelined restoring divider for column and row, one quotient bit a stage,
// followed by the range test. Only quotients below 4096 matter, so the
// quotient is tracked to 13 bits with an overflow flag.
// ----------------------------------------------------------------------------
module ppc_divide
  import ppc_pkg::*;
(
  input  logic              clk,
  input  proj_t             proj,
  input  logic [11:0]       w_used,
  input  logic [11:0]       h_used,
  output hit_t              hit
);

  localparam int QB = 13;                 // quotient bits kept
  localparam int NB = DotBits;            // magnitude width
  localparam int ST = QB + 1;             // pipeline depth

  typedef struct packed {
    logic            ok;      // pz > 0
    logic [NB-1:0]   den;
    logic [NB-1:0]   rem_c;
    logic [NB-1:0]   rem_r;
    logic [QB-1:0]   q_c;
    logic [QB-1:0]   q_r;
    logic            neg_c;
    logic            neg_r;
    logic            big_c;
    logic            big_r;
  } dstage_t;

  dstage_t st_r [ST];
  dstage_t st_nxt [ST];
  logic [NB-1:0] abs_x, abs_y;
  logic [NB+QB-1:0] dsh;
  hit_t hit_r;

  assign abs_x = proj.px[NB-1] ? NB'(-proj.px) : NB'(proj.px);
  assign abs_y = proj.py[NB-1] ? NB'(-proj.py) : NB'(proj.py);

  always_comb begin
    logic [NB+QB-1:0] d;
    // stage 0 sets up magnitudes and flags overflow of the quotient
    st_nxt[0].ok    = !proj.pz[NB-1] && (proj.pz != '0);
    st_nxt[0].den   = NB'(proj.pz);
    st_nxt[0].rem_c = abs_x;
    st_nxt[0].rem_r = abs_y;
    st_nxt[0].q_c   = '0;
    st_nxt[0].q_r   = '0;
    st_nxt[0].neg_c = proj.px[NB-1];
    st_nxt[0].neg_r = proj.py[NB-1];
    dsh = {proj.pz[NB-1:0], QB'(0)};
    st_nxt[0].big_c = ({QB'(0), abs_x} >= dsh);
    st_nxt[0].big_r = ({QB'(0), abs_y} >= dsh);
    for (int s = 1; s < ST; s++) begin
      st_nxt[s] = st_r[s-1];
      d = {QB'(0), st_r[s-1].den} << (QB - s);
      if ({QB'(0), st_r[s-1].rem_c} >= d) begin
        st_nxt[s].rem_c = NB'({QB'(0), st_r[s-1].rem_c} - d);
        st_nxt[s].q_c[QB-s] = 1'b1;
      end
      if ({QB'(0), st_r[s-1].rem_r} >= d) begin
        st_nxt[s].rem_r = NB'({QB'(0), st_r[s-1].rem_r} - d);
        st_nxt[s].q_r[QB-s] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < ST; s++) begin
      st_r[s] <= st_nxt[s];
    end
  end

  // a negative quotient truncating to zero is still inside
  always_ff @(posedge clk) begin
    hit_r.hit <= st_r[ST-1].ok
      && !st_r[ST-1].big_c && !st_r[ST-1].big_r
      && (!st_r[ST-1].neg_c || st_r[ST-1].q_c == '0)
      && (!st_r[ST-1].neg_r || st_r[ST-1].q_r == '0)
      && ({1'b0, st_r[ST-1].q_c} < {2'b0, w_used})
      && ({1'b0, st_r[ST-1].q_r} < {2'b0, h_used});
    hit_r.col <= st_r[ST-1].q_c[11:0];
    hit_r.row <= st_r[ST-1].q_r[11:0];
  end

  assign hit = hit_r;

endmodule

[hdl/ppc_checker.sv]
// ----------------------------------------------------------------------------
// ppc_checker
// Port level checks on the colorizer.
// ----------------------------------------------------------------------------
module ppc_checker
  import ppc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // no result without a transfer, or a reset, the pipeline depth earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 19) || !$past(rst_n, 19)) else $error("phantom result");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.color_found |->
      out_item.red == 8'd0 && out_item.green == 8'd0 && out_item.blue == 8'd0
      && !out_item.source_camera) else $error("not found must be black");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy) else $error("busy raised");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");

endmodule

bind point_projection_colorizer_core ppc_checker u_ppc_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
